// ===== hdl/rcrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rcrb_pkg: shared types and constants
// Word formats, command codes and the internal operation word that the
// front hands to the back through the queue.
// ----------------------------------------------------------------------------
package rcrb_pkg;

  localparam int RING_DEPTH  = 65536;
  localparam int ADDR_W      = $clog2(RING_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 24;
  localparam int FRAME_W     = 2 * SAMPLE_W;
  localparam int QUEUE_DEPTH = 2;  // power of two

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_ARM     = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_REPLY
  } op_kind_e;

  typedef struct packed {
    cmd_e                        command;
    logic signed [SAMPLE_W-1:0]  left_in;
    logic signed [SAMPLE_W-1:0]  right_in;
    logic                        mute;
    logic [LEN_W-1:0]            request_length;
    logic [ADDR_W-1:0]           read_index;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  left_out;
    logic signed [SAMPLE_W-1:0]  right_out;
    logic [ADDR_W-1:0]           position_value;
    logic [LEN_W-1:0]            length_value;
    logic                        valid_res;
  } out_word_t;

  // operation word between front and back
  typedef struct packed {
    op_kind_e                    kind;
    logic [ADDR_W-1:0]           addr;
    logic [SAMPLE_W-1:0]         left;
    logic [SAMPLE_W-1:0]         right;
    logic                        mute;
    logic [ADDR_W-1:0]           pos;
    logic [LEN_W-1:0]            lenv;
  } op_t;

  typedef struct packed {
    logic                        start;
    logic [LEN_W-1:0]            dividend;
    logic [LEN_W-1:0]            divisor;
  } mod_req_t;

  typedef struct packed {
    logic                        done;
    logic [ADDR_W-1:0]           rem;
  } mod_rsp_t;

endpackage

// ===== hdl/rcrb_mod.sv =====
// ----------------------------------------------------------------------------
// rcrb_mod: iterative remainder unit
// Restoring remainder, one dividend bit per cycle. Divisor must be nonzero
// and no larger than the ring depth.
// ----------------------------------------------------------------------------
module rcrb_mod (
  input  logic             clk,
  input  logic             rst,
  input  rcrb_pkg::mod_req_t req,
  output rcrb_pkg::mod_rsp_t rsp
);
  import rcrb_pkg::*;

  localparam int CNT_W = $clog2(LEN_W + 1);

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    count;
  logic [LEN_W-1:0]    shreg;
  logic [LEN_W-1:0]    divisor;
  logic [ADDR_W-1:0]   rem;
  logic [LEN_W-1:0]    trial;
  logic [LEN_W-1:0]    diff;

  assign trial = {rem, shreg[LEN_W-1]};
  assign diff  = trial - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        count   <= CNT_W'(LEN_W);
        shreg   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        rem   <= (trial >= divisor) ? diff[ADDR_W-1:0] : trial[ADDR_W-1:0];
        shreg <= {shreg[LEN_W-2:0], 1'b0};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

// ===== hdl/rcrb_fifo.sv =====
// ----------------------------------------------------------------------------
// rcrb_fifo: operation queue
// Small register queue decoupling command handling from memory access.
// ----------------------------------------------------------------------------
module rcrb_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rcrb_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output rcrb_pkg::op_t pop_data,
  output logic          empty
);
  import rcrb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t              entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/rcrb_front.sv =====
// ----------------------------------------------------------------------------
// rcrb_front: command front end
// Accepts words, keeps ring and readout state, resolves addresses and
// queues write, read and reply operations for the back end.
// ----------------------------------------------------------------------------
module rcrb_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  rcrb_pkg::in_word_t        item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rcrb_pkg::LEN_W-1:0] cfg_data,
  output logic                      q_push,
  output rcrb_pkg::op_t             q_op,
  input  logic                      q_full,
  output rcrb_pkg::mod_req_t        mod_req,
  input  rcrb_pkg::mod_rsp_t        mod_rsp
);
  import rcrb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ARM,
    S_READ
  } state_t;

  localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(RING_DEPTH);

  state_t             state;
  logic [LEN_W-1:0]   ring_length;
  logic [ADDR_W-1:0]  write_position;
  logic               has_wrapped;
  logic [ADDR_W-1:0]  marked_position;
  logic [ADDR_W-1:0]  readout_start;
  logic [LEN_W-1:0]   readout_length;
  logic [LEN_W-1:0]   arm_n;
  logic [ADDR_W-1:0]  rem_reg;
  logic               div_for_arm;

  logic               accept;
  logic [LEN_W-1:0]   len;
  logic [ADDR_W-1:0]  cap_pos;
  logic [LEN_W-1:0]   cap_inc;
  logic               cap_wrap;
  logic [LEN_W-1:0]   marked_ext;
  logic [LEN_W-1:0]   n_eff;
  logic [LEN_W-1:0]   unwrap_diff;
  logic [ADDR_W-1:0]  unwrap_start;
  logic [LEN_W-1:0]   unwrap_len;
  logic [LEN_W:0]     arm_sum;
  logic [LEN_W:0]     arm_sub;
  logic [ADDR_W-1:0]  arm_start;
  logic [LEN_W-1:0]   rd_sum;
  logic               rd_hit;
  logic               arm_div;
  logic               rd_div;

  assign cfg_ready  = 1'b1;
  assign item_stall = !((state == S_IDLE) && !q_full);
  assign accept     = item_valid && !item_stall;

  // ring length in use: zero acts as one, oversize clamps to depth
  assign len = (ring_length == '0) ? LEN_W'(1) :
               (ring_length > DEPTH_L) ? DEPTH_L : ring_length;

  // capture position and advance
  assign cap_pos  = ({1'b0, write_position} >= len) ? '0 : write_position;
  assign cap_inc  = {1'b0, cap_pos} + LEN_W'(1);
  assign cap_wrap = (cap_inc >= len);

  // arm readout
  assign marked_ext   = {1'b0, marked_position};
  assign n_eff        = (item.request_length > len) ? len : item.request_length;
  assign unwrap_diff  = marked_ext - n_eff;
  assign unwrap_start = (marked_ext >= n_eff) ? unwrap_diff[ADDR_W-1:0] : '0;
  assign unwrap_len   = (marked_ext >= n_eff) ? n_eff : marked_ext;
  assign arm_div      = has_wrapped && (marked_ext >= len);

  // wrapped start: (m + len - n) with m < len, n <= len, so one fold
  assign arm_sum   = {2'b00, rem_reg} + {1'b0, len} - {1'b0, arm_n};
  assign arm_sub   = arm_sum - {1'b0, len};
  assign arm_start = (arm_sum >= {1'b0, len}) ? arm_sub[ADDR_W-1:0]
                                              : arm_sum[ADDR_W-1:0];

  // read addressing
  assign rd_sum = {1'b0, readout_start} + {1'b0, item.read_index};
  assign rd_hit = ({1'b0, item.read_index} < readout_length);
  assign rd_div = rd_hit && (rd_sum >= len);

  always_comb begin
    mod_req.start    = 1'b0;
    mod_req.dividend = (item.command == CMD_ARM) ? marked_ext : rd_sum;
    mod_req.divisor  = len;
    if (accept) begin
      if (item.command == CMD_ARM) begin
        mod_req.start = arm_div;
      end else if (item.command == CMD_READ) begin
        mod_req.start = rd_div;
      end
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_op   = '0;
    q_op.kind = OP_REPLY;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.command)
            CMD_CAPTURE: begin
              q_push     = 1'b1;
              q_op.kind  = OP_WRITE;
              q_op.addr  = cap_pos;
              q_op.left  = item.left_in;
              q_op.right = item.right_in;
              q_op.mute  = item.mute;
            end
            CMD_MARK: begin
              q_push   = 1'b1;
              q_op.pos = write_position;
            end
            CMD_ARM: begin
              q_push    = !has_wrapped;
              q_op.pos  = unwrap_start;
              q_op.lenv = unwrap_len;
            end
            CMD_READ: begin
              if (!rd_hit) begin
                q_push = 1'b1;
              end else if (!rd_div) begin
                q_push    = 1'b1;
                q_op.kind = OP_READ;
                q_op.addr = rd_sum[ADDR_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ARM: begin
        q_push    = !q_full;
        q_op.pos  = arm_start;
        q_op.lenv = arm_n;
      end
      S_READ: begin
        q_push    = !q_full;
        q_op.kind = OP_READ;
        q_op.addr = rem_reg;
      end
      S_DIV: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      ring_length     <= DEPTH_L;
      write_position  <= '0;
      has_wrapped     <= 1'b0;
      marked_position <= '0;
      readout_start   <= '0;
      readout_length  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ring_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.command)
              CMD_CAPTURE: begin
                write_position <= cap_wrap ? '0 : cap_inc[ADDR_W-1:0];
                if (cap_wrap) begin
                  has_wrapped <= 1'b1;
                end
              end
              CMD_MARK: begin
                marked_position <= write_position;
              end
              CMD_ARM: begin
                arm_n <= n_eff;
                if (has_wrapped) begin
                  if (arm_div) begin
                    div_for_arm <= 1'b1;
                    state       <= S_DIV;
                  end else begin
                    rem_reg <= marked_position;
                    state   <= S_ARM;
                  end
                end else begin
                  readout_start  <= unwrap_start;
                  readout_length <= unwrap_len;
                end
              end
              CMD_READ: begin
                if (rd_div) begin
                  div_for_arm <= 1'b0;
                  state       <= S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (mod_rsp.done) begin
            rem_reg <= mod_rsp.rem;
            state   <= div_for_arm ? S_ARM : S_READ;
          end
        end
        S_ARM: begin
          if (!q_full) begin
            readout_start  <= arm_start;
            readout_length <= arm_n;
            state          <= S_IDLE;
          end
        end
        S_READ: begin
          if (!q_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rcrb_back.sv =====
// ----------------------------------------------------------------------------
// rcrb_back: frame store and result stage
// Executes queued operations against the frame memory and drives the
// registered result channel.
// ----------------------------------------------------------------------------
module rcrb_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rcrb_pkg::op_t      q_op,
  output logic               q_pop,
  output logic               result_valid,
  input  logic               result_stall,
  output rcrb_pkg::out_word_t result
);
  import rcrb_pkg::*;

  logic [FRAME_W-1:0] frame_store [RING_DEPTH];
  logic [FRAME_W-1:0] rd_data;
  logic               s1_valid;
  op_t                s1_op;
  logic               out_load;
  out_word_t          res_next;

  assign out_load = s1_valid && (!result_valid || !result_stall);
  assign q_pop    = !q_empty && (!s1_valid || out_load);

  always_ff @(posedge clk) begin
    if (q_pop && (q_op.kind == OP_WRITE)) begin
      frame_store[q_op.addr] <= {q_op.left, q_op.right};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data <= frame_store[q_op.addr];
      s1_op   <= q_op;
    end
  end

  always_comb begin
    res_next = '0;
    unique case (s1_op.kind)
      OP_WRITE: begin
        if (!s1_op.mute) begin
          res_next.left_out  = s1_op.left;
          res_next.right_out = s1_op.right;
        end
      end
      OP_READ: begin
        res_next.left_out  = rd_data[FRAME_W-1:SAMPLE_W];
        res_next.right_out = rd_data[SAMPLE_W-1:0];
        res_next.valid_res = 1'b1;
      end
      OP_REPLY: begin
        res_next.position_value = s1_op.pos;
        res_next.length_value   = s1_op.lenv;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/retrospective_capture_ring_buffer_core.sv =====
// ----------------------------------------------------------------------------
// retrospective_capture_ring_buffer_core: stereo capture ring with readout
// Captures stereo frames into a ring, marks a position, arms a readout
// window ending at the mark and reads frames back from that window.
// ----------------------------------------------------------------------------
//
//  channel   signals                          direction  meaning
//  --------  -------------------------------  ---------  -------------------------
//  item      item_valid / item_stall / item   in         command words
//  result    result_valid / result_stall /    out        one result word per item
//            result
//  cfg       cfg_valid / cfg_ready / cfg_data in         ring length register
//
//  Capture, mark and most reads are handled directly in the idle state
//  of the front end. An arm after the first wrap passes through S_ARM.
//  A read whose offset runs past the ring end, or an arm whose mark lies
//  beyond a shortened ring, goes through the bit-serial remainder unit
//  (state S_DIV) first. The queue is written at the accepting edge, then the
//  memory read stage and the result register follow in that order, each of
//  which can be held by a result stall. Reset (rst, synchronous) clears
//  control state only; the frame memory is not cleared. A stalled result is
//  held in the result register while the queue and memory stage keep
//  filling, then item_stall rises once the queue is full.
//
module retrospective_capture_ring_buffer_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  rcrb_pkg::in_word_t         item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output rcrb_pkg::out_word_t        result,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rcrb_pkg::LEN_W-1:0] cfg_data
);
  import rcrb_pkg::*;

  // front -> queue -> back
  logic     q_push;
  op_t      q_push_op;
  logic     q_full;
  logic     q_pop;
  op_t      q_pop_op;
  logic     q_empty;
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  rcrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_push     (q_push),
    .q_op       (q_push_op),
    .q_full     (q_full),
    .mod_req    (mod_req),
    .mod_rsp    (mod_rsp)
  );

  // remainder unit for ring-relative addressing
  rcrb_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  rcrb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_op),
    .empty     (q_empty)
  );

  rcrb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_op         (q_pop_op),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // queue never written when full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("operation queue overflow");

  // queue never read when empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("operation queue underflow");

  // a valid read carries no position or length
  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.valid_res) |->
      (result.position_value == '0 && result.length_value == '0))
    else $error("read result with position or length set");

  // a word is only taken by an idle front end with queue room
  a_accept_room: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> !(q_push && $past(q_full)))
    else $error("word accepted without queue room");

endmodule
